>>> hw/rtl/ssw_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_pkg
// Shared widths, defaults and controller/datapath command and status types.
// ----------------------------------------------------------------------------
package ssw_pkg;

  localparam int unsigned MAX_SUM   = 1000;
  localparam int unsigned MAX_ITEMS = 20;
  localparam int unsigned VALUE_W   = 10;
  localparam int unsigned TARGET_W  = 11;
  localparam int unsigned COUNT_W   = 21;

  localparam logic [COUNT_W-1:0] COUNT_MAX = '1;

  typedef struct packed {
    logic load;
    logic issue;
    logic finish;
  } ctrl_cmd_t;

  typedef struct packed {
    logic sweep_end;
  } ctrl_sts_t;

endpackage

>>> hw/rtl/signed_sum_way_counter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// signed_sum_way_counter
// Counts the sign assignments of a set of numbers that reach a target sum.
// ----------------------------------------------------------------------------
// Each item is accepted in idle and then handled in full before the next one
// can be taken: the table of 2*MaxSum+1 counts is swept one entry per cycle
// from one bank into the other, then the flush state drains the
// read/add/write pipe, the finish state swaps banks, and the sequencer
// returns to idle to take the next item. busy is high for the whole sweep.
// On an item marked last, done_o pulses for one cycle with ways_o and
// overflow_o; there is no backpressure, so capture the result in that cycle.
// target_sum must be written only while busy is low; the block does not
// enforce this. No clearing pass is needed after reset or a set.
// ----------------------------------------------------------------------------
module signed_sum_way_counter #(
  parameter int unsigned MaxSum   = ssw_pkg::MAX_SUM,
  parameter int unsigned MaxItems = ssw_pkg::MAX_ITEMS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                start,
  output logic                                busy,
  input  logic [ssw_pkg::VALUE_W-1:0]         value_i,
  input  logic                                last_i,
  input  logic                                target_we_i,
  input  logic signed [ssw_pkg::TARGET_W-1:0] target_sum_i,
  output logic                                done_o,
  output logic [ssw_pkg::COUNT_W-1:0]         ways_o,
  output logic                                overflow_o
);

  ssw_pkg::ctrl_cmd_t cmd;
  ssw_pkg::ctrl_sts_t sts;

  ssw_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start  (start),
    .sts_i  (sts),
    .busy   (busy),
    .cmd_o  (cmd)
  );

  ssw_dpath #(
    .MaxSum   (MaxSum),
    .MaxItems (MaxItems)
  ) u_dpath (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cmd_i        (cmd),
    .sts_o        (sts),
    .value_i      (value_i),
    .last_i       (last_i),
    .target_we_i  (target_we_i),
    .target_sum_i (target_sum_i),
    .done_o       (done_o),
    .ways_o       (ways_o),
    .overflow_o   (overflow_o)
  );

`ifndef SYNTH
  a_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (start && !busy) |=> busy)
    else $error("item accepted but sequencer did not go busy");

  a_done_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |-> !busy)
    else $error("result strobe while a sweep is running");

  a_done_single: assert property (@(posedge clk_i) disable iff (!rst_ni)
    done_o |=> !done_o)
    else $error("result strobe longer than one cycle");
`endif

endmodule

>>> hw/rtl/ssw_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_ctrl
// Sequencer: takes an item, sweeps the table once, drains, then finishes.
// ----------------------------------------------------------------------------
module ssw_ctrl (
  input  logic              clk_i,
  input  logic              rst_ni,
  input  logic              start,
  input  ssw_pkg::ctrl_sts_t sts_i,
  output logic              busy,
  output ssw_pkg::ctrl_cmd_t cmd_o
);

  localparam logic [1:0] ST_IDLE   = 2'd0;
  localparam logic [1:0] ST_RUN    = 2'd1;
  localparam logic [1:0] ST_FLUSH  = 2'd2;
  localparam logic [1:0] ST_FINISH = 2'd3;

  logic [1:0] state_q, state_d;

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      ST_IDLE: begin
        if (start) begin
          cmd_o.load = 1'b1;
          state_d    = ST_RUN;
        end
      end
      ST_RUN: begin
        cmd_o.issue = 1'b1;
        if (sts_i.sweep_end) begin
          state_d = ST_FLUSH;
        end
      end
      // let the final write land
      ST_FLUSH: begin
        state_d = ST_FINISH;
      end
      ST_FINISH: begin
        cmd_o.finish = 1'b1;
        state_d      = ST_IDLE;
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign busy = (state_q != ST_IDLE);

endmodule

>>> hw/rtl/ssw_dpath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ssw_dpath
// Ping-pong count tables, sweep address, two-stage read/add/write pipe,
// item count, overflow tracking and the result register.
// ----------------------------------------------------------------------------
module ssw_dpath #(
  parameter int unsigned MaxSum   = ssw_pkg::MAX_SUM,
  parameter int unsigned MaxItems = ssw_pkg::MAX_ITEMS
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  ssw_pkg::ctrl_cmd_t                  cmd_i,
  output ssw_pkg::ctrl_sts_t                  sts_o,
  input  logic [ssw_pkg::VALUE_W-1:0]         value_i,
  input  logic                                last_i,
  input  logic                                target_we_i,
  input  logic signed [ssw_pkg::TARGET_W-1:0] target_sum_i,
  output logic                                done_o,
  output logic [ssw_pkg::COUNT_W-1:0]         ways_o,
  output logic                                overflow_o
);

  localparam int unsigned TableLen = 2 * MaxSum + 1;
  localparam int unsigned AW       = $clog2(TableLen);
  localparam int unsigned IW       = ((AW > ssw_pkg::VALUE_W) ? AW : ssw_pkg::VALUE_W) + 2;
  localparam int unsigned IcW      = $clog2(MaxItems + 1);
  localparam int unsigned CW       = ssw_pkg::COUNT_W;

  // tables
  logic [CW-1:0] bank0_q [TableLen];
  logic [CW-1:0] bank1_q [TableLen];

  // item state
  logic [ssw_pkg::VALUE_W-1:0]         val_q;
  logic                                last_q;
  logic signed [ssw_pkg::TARGET_W-1:0] target_q;
  logic [AW-1:0]                       s_q;
  logic                                cur_q;
  logic                                fresh_q;
  logic                                nz_q;
  logic                                nz_acc_q;
  logic [IcW-1:0]                      items_q;
  logic                                lost_q;
  logic [CW-1:0]                       ways_q;

  // pipe stage
  logic          p_valid_q;
  logic [AW-1:0] p_s_q;
  logic          p_va_q, p_vb_q, p_ca_q, p_cb_q, p_low_q;
  logic [CW-1:0] rd_a_q, rd_b_q;

  // result
  logic          done_q;
  logic [CW-1:0] out_ways_q;
  logic          out_ovf_q;

  // stage 1 addressing
  logic signed [IW-1:0] s_ext, v_ext, ia, ib, center, tlen, tidx;
  logic                 va, vb, tin, big;
  logic [AW-1:0]        addr_a, addr_b;

  always_comb begin
    s_ext  = signed'(IW'(s_q));
    v_ext  = signed'(IW'(val_q));
    center = signed'(IW'(MaxSum));
    tlen   = signed'(IW'(TableLen));
    ia     = s_ext - v_ext;
    ib     = s_ext + v_ext;
    va     = (ia >= 0);
    vb     = (ib < tlen);
    addr_a = va ? ia[AW-1:0] : '0;
    addr_b = vb ? ib[AW-1:0] : '0;
    tidx   = IW'(target_q) + center;
    tin    = (tidx >= 0) && (tidx < tlen);
    big    = (signed'(IW'(value_i)) > center);
  end

  assign sts_o.sweep_end = (s_q == AW'(TableLen - 1));

  // stage 2: form both neighbors, add, saturate
  logic [CW-1:0] a_val, b_val, sat;
  logic [CW:0]   sum;
  logic          lost_hit;

  always_comb begin
    if (fresh_q) begin
      a_val = p_ca_q ? CW'(1) : '0;
      b_val = p_cb_q ? CW'(1) : '0;
    end else begin
      a_val = p_va_q ? rd_a_q : '0;
      b_val = p_vb_q ? rd_b_q : '0;
    end
    sum      = {1'b0, a_val} + {1'b0, b_val};
    sat      = sum[CW] ? ssw_pkg::COUNT_MAX : sum[CW-1:0];
    // table stays symmetric about sum zero, so the low edge alone tells loss
    lost_hit = sum[CW] || (p_low_q && (a_val != '0));
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q && cur_q) begin
      bank0_q[p_s_q] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (p_valid_q && !cur_q) begin
      bank1_q[p_s_q] <= sat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.issue) begin
      rd_a_q <= cur_q ? bank1_q[addr_a] : bank0_q[addr_a];
      rd_b_q <= cur_q ? bank1_q[addr_b] : bank0_q[addr_b];
    end
  end

  // payload registers
  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      val_q  <= value_i;
      last_q <= last_i;
    end
    if (cmd_i.issue) begin
      p_s_q   <= s_q;
      p_va_q  <= va;
      p_vb_q  <= vb;
      p_ca_q  <= va && (ia == center);
      p_cb_q  <= vb && (ib == center);
      p_low_q <= va && (ia < v_ext);
    end
    if (cmd_i.finish) begin
      out_ways_q <= ways_q;
      out_ovf_q  <= lost_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      target_q  <= '0;
      s_q       <= '0;
      cur_q     <= 1'b0;
      fresh_q   <= 1'b1;
      nz_q      <= 1'b1;
      nz_acc_q  <= 1'b0;
      items_q   <= '0;
      lost_q    <= 1'b0;
      ways_q    <= '0;
      p_valid_q <= 1'b0;
      done_q    <= 1'b0;
    end else begin
      p_valid_q <= cmd_i.issue;
      done_q    <= cmd_i.finish && last_q;
      if (target_we_i) begin
        target_q <= target_sum_i;
      end
      if (cmd_i.load) begin
        s_q      <= '0;
        nz_acc_q <= 1'b0;
        ways_q   <= '0;
        if (items_q >= IcW'(MaxItems)) begin
          lost_q <= 1'b1;
        end else begin
          items_q <= items_q + IcW'(1);
        end
        // a step larger than MaxSum pushes every live count off the table on one side
        if (big && nz_q) begin
          lost_q <= 1'b1;
        end
      end
      if (cmd_i.issue && !sts_o.sweep_end) begin
        s_q <= s_q + AW'(1);
      end
      if (p_valid_q) begin
        if (sat != '0) begin
          nz_acc_q <= 1'b1;
        end
        if (lost_hit) begin
          lost_q <= 1'b1;
        end
        if (tin && (p_s_q == tidx[AW-1:0])) begin
          ways_q <= sat;
        end
      end
      if (cmd_i.finish) begin
        cur_q   <= ~cur_q;
        fresh_q <= 1'b0;
        nz_q    <= nz_acc_q;
        // end of set: fall back to the virtual start table
        if (last_q) begin
          fresh_q <= 1'b1;
          nz_q    <= 1'b1;
          items_q <= '0;
          lost_q  <= 1'b0;
        end
      end
    end
  end

  assign done_o     = done_q;
  assign ways_o     = out_ways_q;
  assign overflow_o = out_ovf_q;

endmodule

>>> tb/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for signed_sum_way_counter. A directed block covers the
// widest value, zero values, sums that leave the range, an overlong set with
// a saturating count and targets beyond the range. Random sets follow, many
// with a target that a choice of signs reaches. Each accepted item is folded
// into a local copy of the count table, and each result is compared with the
// oldest expectation.
// ----------------------------------------------------------------------------
module testbench;

  localparam int MAX_ITEMS   = ssw_pkg::MAX_ITEMS;
  localparam int VALUE_W     = ssw_pkg::VALUE_W;
  localparam int TARGET_W    = ssw_pkg::TARGET_W;
  localparam int COUNT_W     = ssw_pkg::COUNT_W;
  localparam int MS          = ssw_pkg::MAX_SUM;
  localparam int TABLE_LEN   = 2 * MS + 1;
  localparam int CNT_SAT     = (1 << COUNT_W) - 1;
  localparam int STALL_LIMIT = 20000;
  localparam int RAND_ITEMS  = 265;

  typedef struct {
    bit                          is_cfg;
    logic [VALUE_W-1:0]          value;
    logic                        last;
    logic signed [TARGET_W-1:0]  target;
  } step_t;

  typedef struct {
    logic [COUNT_W-1:0] ways;
    logic               overflow;
  } tally_t;

  logic                        clk_i        = 1'b0;
  logic                        rst_ni       = 1'b0;
  logic                        start        = 1'b0;
  logic                        busy;
  logic [VALUE_W-1:0]          value_i      = '0;
  logic                        last_i       = 1'b0;
  logic                        target_we_i  = 1'b0;
  logic signed [TARGET_W-1:0]  target_sum_i = '0;
  logic                        done_o;
  logic [COUNT_W-1:0]          ways_o;
  logic                        overflow_o;

  step_t  pending[$];
  tally_t ways_due[$];

  // local copy of the count table and set state
  int                          sign_counts[TABLE_LEN];
  int                          set_len;
  bit                          set_lost;
  logic signed [TARGET_W-1:0]  tgt_model;

  int items_sent  = 0;
  int items_taken = 0;
  int total_items = 0;
  int errors      = 0;
  int gap_left    = 0;
  int settle      = 0;
  int idle_cycles = 0;

  signed_sum_way_counter DUT (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start        (start),
    .busy         (busy),
    .value_i      (value_i),
    .last_i       (last_i),
    .target_we_i  (target_we_i),
    .target_sum_i (target_sum_i),
    .done_o       (done_o),
    .ways_o       (ways_o),
    .overflow_o   (overflow_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  task automatic flag_error(input string msg);
    errors++;
    $display("ERROR at %0t: %s", $realtime, msg);
  endtask

  function automatic void clear_counts();
    foreach (sign_counts[s]) sign_counts[s] = 0;
    sign_counts[MS] = 1;
    set_len  = 0;
    set_lost = 1'b0;
  endfunction

  // Fold one value into the table; on the last item queue the count at target.
  task automatic fold_value(input logic [VALUE_W-1:0] v_in, input logic last_in);
    int     v;
    int     a;
    int     b;
    int     t;
    int     tg;
    int     nxt[TABLE_LEN];
    tally_t res;
    v = v_in;
    if (set_len >= MAX_ITEMS) set_lost = 1'b1;
    else set_len++;
    for (int s = 0; s < TABLE_LEN; s++) begin
      if (sign_counts[s] != 0 && (s + v >= TABLE_LEN || s - v < 0)) set_lost = 1'b1;
    end
    for (int s = 0; s < TABLE_LEN; s++) begin
      a = (s - v >= 0) ? sign_counts[s - v] : 0;
      b = (s + v < TABLE_LEN) ? sign_counts[s + v] : 0;
      t = a + b;
      if (t > CNT_SAT) begin
        t = CNT_SAT;
        set_lost = 1'b1;
      end
      nxt[s] = t;
    end
    sign_counts = nxt;
    if (last_in) begin
      tg = tgt_model;
      res.ways     = (tg >= -MS && tg <= MS) ? COUNT_W'(sign_counts[tg + MS]) : '0;
      res.overflow = set_lost;
      ways_due.push_back(res);
      clear_counts();
    end
  endtask

  function automatic void add_item(input int v, input bit last);
    step_t st;
    st.is_cfg = 1'b0;
    st.value  = VALUE_W'(v);
    st.last   = last;
    st.target = '0;
    pending.push_back(st);
  endfunction

  function automatic void add_target(input int t);
    step_t st;
    st.is_cfg = 1'b1;
    st.value  = '0;
    st.last   = 1'b0;
    st.target = TARGET_W'(t);
    pending.push_back(st);
  endfunction

  // Sender gap after an item: 35 then 55 percent, then none.
  function automatic int pick_gap(input int sent);
    int pct;
    pct = (sent * 3 < total_items) ? 35 : (sent * 3 < 2 * total_items) ? 55 : 0;
    if ($urandom_range(99) >= pct) return 0;
    if ($urandom_range(3) == 0) return $urandom_range(1, 2 * MS + 100);
    return $urandom_range(1, 8);
  endfunction

  function automatic int pick_value(input int scale);
    int r;
    r = $urandom_range(99);
    if (r < 3) return 0;
    if (r < 5) return 1000;
    if (r < 7) return 512;
    if (r < 8) return 511;
    return $urandom_range(0, scale);
  endfunction

  // drive on the falling edge; one assignment per signal per step
  always @(negedge clk_i) begin : drive
    logic                        nxt_start;
    logic                        nxt_we;
    logic                        nxt_last;
    logic [VALUE_W-1:0]          nxt_val;
    logic signed [TARGET_W-1:0]  nxt_tgt;
    step_t                       head;
    nxt_start = start;
    nxt_we    = 1'b0;
    nxt_last  = last_i;
    nxt_val   = value_i;
    nxt_tgt   = target_sum_i;
    if (rst_ni) begin
      if (start && items_taken == items_sent) nxt_start = 1'b0;
      if (!nxt_start) begin
        if (gap_left > 0) begin
          gap_left--;
        end else if (pending.size() > 0) begin
          head = pending[0];
          if (head.is_cfg) begin
            // write only once the block is idle and nothing is owed
            if (ways_due.size() == 0 && !busy) begin
              if (settle < 4) begin
                settle++;
              end else begin
                nxt_we  = 1'b1;
                nxt_tgt = head.target;
                settle  = 0;
                void'(pending.pop_front());
              end
            end else begin
              settle = 0;
            end
          end else begin
            nxt_start = 1'b1;
            nxt_val   = head.value;
            nxt_last  = head.last;
            gap_left  = pick_gap(items_sent);
            items_sent++;
            void'(pending.pop_front());
          end
        end
      end
    end
    start        <= nxt_start;
    target_we_i  <= nxt_we;
    value_i      <= nxt_val;
    last_i       <= nxt_last;
    target_sum_i <= nxt_tgt;
  end

  // sample on the rising edge: accept items, track the target, check results, catch stalls
  always @(posedge clk_i) begin : watch
    tally_t exp_t;
    if (rst_ni) begin
      if (target_we_i) tgt_model = target_sum_i;
      if (start && !busy) begin
        fold_value(value_i, last_i);
        items_taken++;
      end
      if (done_o) begin
        if (ways_due.size() == 0) begin
          flag_error($sformatf("result ways=%0d with nothing expected", ways_o));
        end else begin
          exp_t = ways_due.pop_front();
          if (ways_o !== exp_t.ways)
            flag_error($sformatf("ways %0d, expected %0d", ways_o, exp_t.ways));
          if (overflow_o !== exp_t.overflow)
            flag_error($sformatf("overflow %0b, expected %0b", overflow_o, exp_t.overflow));
        end
      end
      if ((start && !busy) || done_o || target_we_i) idle_cycles = 0;
      else idle_cycles++;
      if (idle_cycles >= STALL_LIMIT) begin
        $display("signed_sum_way_counter: mismatch");
        $finish;
      end
    end
  end

  initial begin : stimulus
    int rnd_items;
    int len;
    int scale;
    int r;
    int ssum;
    int vals[$];
    clear_counts();
    tgt_model = '0;

    // overlong set of zeros at the reset target: count saturates
    for (int i = 0; i < 21; i++) add_item(0, i == 20);
    // widest value, widest in-range target
    add_target(1000);
    add_item(1000, 1'b1);
    // zero value, target above the range
    add_target(1023);
    add_item(0, 1'b1);
    // sums of +-2000 leave the range, target below the range
    add_target(-1024);
    add_item(1000, 1'b0);
    add_item(1000, 1'b1);

    rnd_items = 0;
    while (rnd_items < RAND_ITEMS) begin
      r = $urandom_range(99);
      len = (r < 70) ? $urandom_range(1, 5) : (r < 92) ? $urandom_range(6, 14) :
            (r < 97) ? $urandom_range(15, 20) : $urandom_range(21, 23);
      r = $urandom_range(99);
      scale = (r < 40) ? 7 : (r < 70) ? 63 : (r < 88) ? 300 : 1000;
      vals.delete();
      ssum = 0;
      for (int i = 0; i < len; i++) begin
        vals.push_back(pick_value(scale));
        ssum += $urandom_range(1) ? vals[i] : -vals[i];
      end
      if ($urandom_range(99) < 75) begin
        r = $urandom_range(99);
        if (r < 60 && ssum >= -1024 && ssum <= 1023) add_target(ssum);
        else if (r < 80) add_target($signed($urandom_range(2000)) - 1000);
        else if (r < 90) add_target($urandom_range(1) ? 1000 : -1000);
        else if ($urandom_range(1)) add_target($urandom_range(1001, 1023));
        else add_target(-$signed($urandom_range(1001, 1024)));
      end
      for (int i = 0; i < len; i++) add_item(vals[i], i == len - 1);
      rnd_items += len;
    end

    foreach (pending[i]) if (!pending[i].is_cfg) total_items++;

    repeat (10) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    wait (pending.size() == 0);
    wait (items_taken == items_sent && ways_due.size() == 0);
    while (busy) @(posedge clk_i);
    repeat (2 * MS + 8) @(posedge clk_i);
    if (errors == 0) begin
      $display("signed_sum_way_counter: match");
    end else begin
      $display("signed_sum_way_counter: mismatch");
    end
    $finish;
  end

endmodule
